FILE: hw/rtl/prp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prp_pkg
// Shared types, field widths and codes for the partition router and pruner.
// ----------------------------------------------------------------------------
package prp_pkg;

	localparam int MaxParts    = 16;
	localparam int ListEntries = 64;
	localparam int KeyBits     = 32;
	localparam int PartBits    = $clog2(MaxParts);
	localparam int ListBits    = $clog2(ListEntries);

	typedef enum logic [1:0] {
		CMD_LOAD_RANGE = 2'd0,
		CMD_LOAD_LIST  = 2'd1,
		CMD_ROUTE      = 2'd2,
		CMD_PRED       = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		OP_EQ = 3'd0,
		OP_LT = 3'd1,
		OP_LE = 3'd2,
		OP_GT = 3'd3,
		OP_GE = 3'd4
	} op_t;

	localparam logic [1:0] REG_MODE       = 2'd0;
	localparam logic [1:0] REG_PART_COUNT = 2'd1;
	localparam logic [1:0] REG_KEY_COLUMN = 2'd2;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [5:0]         entry_index;
		logic signed [31:0] key;
		logic               bound_open;
		logic [3:0]         part_id;
		logic [2:0]         pred_op;
		logic [7:0]         pred_column;
		logic               last_pred;
	} in_item_t;

	typedef struct packed {
		logic        result_kind;
		logic [3:0]  partition;
		logic        match_found;
		logic [15:0] part_mask;
	} out_item_t;

	// commands from controller to datapath
	typedef struct packed {
		logic capture;   // latch the accepted item
		logic clear;     // clear the per-item accumulators
		logic step_rng;  // evaluate one range slot
		logic step_lst;  // evaluate one list entry
		logic finish;    // form the result
		logic [ListBits-1:0] idx;
	} dp_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic [1:0] cmd;
		logic       mode;
		logic       col_hit;
		logic       last_pred;
		logic       eq_taken;
		logic [PartBits:0] n;
	} dp_sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/prp_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prp_ctrl
// Sequencer: accepts an item, walks range slots or list entries, emits a result for routes and last predicates.
// ----------------------------------------------------------------------------
module prp_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	input  wire prp_pkg::dp_sts_t sts,
	output prp_pkg::dp_cmd_t      cmd
);

	typedef enum logic [2:0] {S_IDLE, S_DISP, S_RNG, S_LST, S_LTAIL, S_FIN} state_t;

	state_t state_q;
	logic [prp_pkg::ListBits-1:0] idx_q;
	logic out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.idx      = idx_q;
		cmd.capture  = in_valid && in_ready;
		cmd.clear    = (state_q == S_DISP);
		cmd.step_rng = (state_q == S_RNG);
		cmd.step_lst = (state_q == S_LST);
		cmd.finish   = (state_q == S_FIN) && !out_valid_q;
	end

	// state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_DISP;
				end
				S_DISP: begin
					idx_q <= '0;
					if (sts.cmd == prp_pkg::CMD_ROUTE) begin
						state_q <= sts.mode ? S_LST : S_RNG;
					end else if (sts.cmd == prp_pkg::CMD_PRED) begin
						if (sts.col_hit && !sts.mode) state_q <= S_RNG;
						else if (sts.col_hit && !sts.eq_taken) state_q <= S_LST;
						else state_q <= S_FIN;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_RNG: begin
					idx_q <= idx_q + 1'b1;
					if ({1'b0, idx_q} + 1'b1 >= {{(prp_pkg::ListBits-prp_pkg::PartBits){1'b0}},
						sts.n}) state_q <= S_FIN;
				end
				S_LST: begin
					idx_q <= idx_q + 1'b1;
					if (&idx_q) state_q <= S_LTAIL;
				end
				// last list entry is still in the read register
				S_LTAIL: begin
					state_q <= S_FIN;
				end
				// wait for a pending result before touching the output
				S_FIN: begin
					if (!out_valid_q) begin
						if (!(sts.cmd == prp_pkg::CMD_PRED && !sts.last_pred))
							out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/prp_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prp_dp
// Datapath: bound and list tables, range and list compare logic, mask accumulators.
// ----------------------------------------------------------------------------
module prp_dp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire prp_pkg::in_item_t in_item,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [7:0]        cfg_data,
	input  wire prp_pkg::dp_cmd_t  cmd,
	output prp_pkg::dp_sts_t       sts,
	output prp_pkg::out_item_t     out_item
);

	localparam int NP = prp_pkg::MaxParts;
	localparam int NL = prp_pkg::ListEntries;

	logic        mode_q;
	logic [4:0]  part_count_q;
	logic [7:0]  key_column_q;

	prp_pkg::in_item_t item_q;
	logic [31:0] bound_q [NP];
	logic        open_q [NP];
	logic [31:0] lval_q [NL];
	logic [3:0]  lown_q [NL];
	logic [NL-1:0] lvalid_q;
	logic [NP-1:0] prune_q;
	logic        eq_taken_q;
	logic [NP-1:0] acc_q;
	logic [3:0]  part_q;
	logic        found_q;
	logic        hit_q;
	prp_pkg::out_item_t out_q;

	logic [31:0] lv_s1;
	logic [3:0]  lown_s1;
	logic        lvld_s1;
	logic        lstep_s1;

	logic [4:0]  n;
	logic [NP-1:0] all_m;
	logic [31:0] k;
	logic [3:0]  ri;
	logic [31:0] hi, lo;
	logic        hi_none, lo_none, may;
	logic [31:0] lv;
	logic [3:0]  lo_own;
	logic        lhit;

	// active partition count
	always_comb begin
		if (part_count_q == 5'd0) n = 5'd1;
		else if (part_count_q > 5'(NP)) n = 5'(NP);
		else n = part_count_q;
		for (int j = 0; j < NP; j++) all_m[j] = (5'(j) < n);
	end

	assign k = item_q.key ^ 32'h8000_0000;
	assign ri = cmd.idx[3:0];

	// one range slot compare
	always_comb begin
		hi      = bound_q[ri] ^ 32'h8000_0000;
		hi_none = open_q[ri];
		lo      = (ri == 4'd0) ? 32'd0 : bound_q[ri - 4'd1] ^ 32'h8000_0000;
		lo_none = (ri == 4'd0) || open_q[ri - 4'd1];
		case (item_q.pred_op) inside
			prp_pkg::OP_EQ: may = (lo_none || k >= lo) && (hi_none || k < hi);
			prp_pkg::OP_LT: may = lo_none || lo < k;
			prp_pkg::OP_LE: may = lo_none || lo <= k;
			prp_pkg::OP_GT, prp_pkg::OP_GE: may = hi_none || k < hi;
			default: may = 1'b1;
		endcase
	end

	// registered read of one list entry
	always_ff @(posedge clk) begin
		lv_s1   <= lval_q[cmd.idx];
		lown_s1 <= lown_q[cmd.idx];
		lvld_s1 <= lvalid_q[cmd.idx];
	end

	// one list entry compare, in the cycle after its walk index
	assign lv     = lv_s1;
	assign lo_own = lown_s1;
	assign lhit   = lvld_s1 && ({1'b0, lo_own} < n) && (lv == item_q.key);

	assign sts.cmd       = item_q.cmd;
	assign sts.mode      = mode_q;
	assign sts.col_hit   = (item_q.pred_column == key_column_q);
	assign sts.last_pred = item_q.last_pred;
	assign sts.eq_taken  = eq_taken_q;
	assign sts.n         = n;
	assign out_item      = out_q;

	// configuration registers and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= 1'b0;
			part_count_q <= 5'd1;
			key_column_q <= 8'd0;
			lvalid_q     <= '0;
			prune_q      <= '1;
			eq_taken_q   <= 1'b0;
			lstep_s1     <= 1'b0;
		end else begin
			lstep_s1 <= cmd.step_lst;
			if (cfg_we) begin
				unique case (cfg_index)
					prp_pkg::REG_MODE:       mode_q       <= cfg_data[0];
					prp_pkg::REG_PART_COUNT: part_count_q <= cfg_data[4:0];
					prp_pkg::REG_KEY_COLUMN: key_column_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.clear && item_q.cmd == prp_pkg::CMD_LOAD_LIST)
				lvalid_q[item_q.entry_index] <= 1'b1;
			if (cmd.finish && item_q.cmd == prp_pkg::CMD_PRED) begin
				if (sts.col_hit && !mode_q)
					prune_q <= prune_q & (acc_q | ~all_m);
				else if (sts.col_hit && item_q.pred_op == prp_pkg::OP_EQ && !eq_taken_q) begin
					prune_q    <= acc_q;
					eq_taken_q <= 1'b1;
				end
				if (item_q.last_pred) begin
					prune_q    <= '1;
					eq_taken_q <= 1'b0;
				end
			end
		end
	end

	// item capture, table writes, walk accumulators, result
	always_ff @(posedge clk) begin
		if (cmd.capture) item_q <= in_item;
		if (cmd.clear) begin
			acc_q   <= '0;
			part_q  <= 4'(n - 5'd1);
			found_q <= 1'b0;
			hit_q   <= 1'b0;
			if (item_q.cmd == prp_pkg::CMD_LOAD_RANGE && item_q.entry_index < 6'(NP)) begin
				bound_q[item_q.entry_index[3:0]] <= item_q.key;
				open_q[item_q.entry_index[3:0]]  <= item_q.bound_open;
			end
			if (item_q.cmd == prp_pkg::CMD_LOAD_LIST) begin
				lval_q[item_q.entry_index] <= item_q.key;
				lown_q[item_q.entry_index] <= item_q.part_id;
			end
		end
		if (cmd.step_rng) begin
			if (item_q.cmd == prp_pkg::CMD_ROUTE) begin
				if (!hit_q && (open_q[ri] || k < (bound_q[ri] ^ 32'h8000_0000))) begin
					hit_q  <= 1'b1;
					part_q <= ri;
				end
			end else begin
				acc_q[ri] <= may;
			end
		end
		if (lstep_s1 && lhit) begin
			acc_q[lo_own] <= 1'b1;
			if (!found_q || lo_own < part_q) part_q <= lo_own;
			found_q <= 1'b1;
		end
		if (cmd.finish) begin
			if (item_q.cmd == prp_pkg::CMD_ROUTE) begin
				out_q.result_kind <= 1'b0;
				out_q.partition   <= (mode_q && !found_q) ? 4'd0 : part_q;
				out_q.match_found <= mode_q ? found_q : 1'b1;
				out_q.part_mask   <= '0;
			end else begin
				out_q.result_kind <= 1'b1;
				out_q.partition   <= 4'd0;
				out_q.match_found <= 1'b0;
				if (sts.col_hit && !mode_q)
					out_q.part_mask <= prune_q & acc_q & all_m;
				else if (sts.col_hit && item_q.pred_op == prp_pkg::OP_EQ && !eq_taken_q)
					out_q.part_mask <= acc_q & all_m;
				else
					out_q.part_mask <= prune_q & all_m;
			end
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/partition_router_pruner.sv
`default_nettype none
// ----------------------------------------------------------------------------
// partition_router_pruner
// Range/list partition routing and predicate pruning over loaded tables.
// ----------------------------------------------------------------------------
// Load items write their table entry and give no result; a predicate off the
// key column skips the walk. Items are taken one at a time, and the compare
// logic steps over one bound slot or one list entry per cycle; a waiting
// result holds it.
// Reset: registers to mode 0, part_count 1, key_column 0; list valid bits
// cleared, prune mask all ones; tables hold no reset value.
module partition_router_pruner (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire prp_pkg::in_item_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output prp_pkg::out_item_t      out_data,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [7:0]         cfg_data
);

	prp_pkg::dp_cmd_t cmd;
	prp_pkg::dp_sts_t sts;

	prp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
	);

	prp_dp u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_data), .cfg_we(cfg_we),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .cmd(cmd), .sts(sts),
		.out_item(out_data)
	);

endmodule
`default_nettype wire
